// ----- rtl/lscs_pkg.sv -----
// Shared constants, codes and types of the light sample calibrate and scale unit.
package lscs_pkg;

   // Converter sample width and the length of a calibration run as a power of two.
   localparam int SAMPLE_W   = 10;
   localparam int AVG_SHIFT  = 4;
   localparam int RUN_LEN    = 1 << AVG_SHIFT;

   // Field and datapath widths.
   localparam int KIND_W     = 2;
   localparam int READ_W     = SAMPLE_W + 1;
   localparam int PCT_W      = 7;
   localparam int DIFF_W     = READ_W + 1;
   localparam int NUM_W      = DIFF_W + PCT_W;
   localparam int DIVIDEND_W = NUM_W - 1;
   localparam int DIVISOR_W  = DIFF_W - 1;
   localparam int REM_W      = DIVISOR_W + 1;
   localparam int STEP_W     = $clog2(DIVIDEND_W);
   localparam int SUM_W      = READ_W + AVG_SHIFT;

   // Configuration port.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = READ_W;

   // Percentage scale and reset values of the registers and points.
   localparam int PCT_MAX       = 100;
   localparam int BASE_RESET    = (1 << SAMPLE_W) - 1;
   localparam int LOW_RESET     = 0;
   localparam int HIGH_RESET    = (1 << SAMPLE_W) - 1;

   // Item kinds; the unused code is handled as a measurement.
   localparam logic [KIND_W-1:0] KIND_MEASURE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_LOW_CAL  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_HIGH_CAL = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE     = 2'd0;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_VALUE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_DEFAULT  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_DEFAULT = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MUL,
      ST_SIGN,
      ST_DIV,
      ST_DONE
   } state_type;

   // Divider command and status.
   typedef struct packed {
      logic                  start;
      logic [DIVIDEND_W-1:0] dividend;
      logic [DIVISOR_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                  done;
      logic [DIVIDEND_W-1:0] quotient;
   } div_rsp_type;

endpackage

// ----- rtl/light_sample_calibrate_scale_unit.sv -----
// Top level of the light sample calibrate and scale unit with its sequencer.
//
// Each accepted item is one converter sample, inverted as base_value minus
// sample. A calibration item adds that reading to a 16-sample run in the
// prep step and is then done. A measure item maps the reading between the low
// and high points to a percentage clamped to 0..100, through the prep,
// multiply, sign and divide steps, with the 18-step serial divider forming the
// quotient. When the result is known to be zero without division, the divide
// step is skipped. The input stalls while an item is in work. A finished
// result waits in the output register and the next item is accepted meanwhile;
// while that register is held by a stalled output, the following finished item
// waits in its last step. Writing a default register also loads the matching
// working point.
module light_sample_calibrate_scale_unit
   import lscs_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   // Item input
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [KIND_W-1:0]            req_kind,
   input  logic [SAMPLE_W-1:0]          req_sample,
   // Result output
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [READ_W-1:0]     rsp_reading,
   output logic [PCT_W-1:0]             rsp_percent,
   output logic                         rsp_calib_done,
   output logic                         rsp_calib_ok,
   // Configuration writes
   input  logic                         csr_write,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   state_type state_ff, state_in;

   // Sequencer controls.
   logic load_item, do_prep, do_mul, do_sign, div_finish, rsp_load;
   logic is_cal, trivial_zero;

   // Configuration and calibration state.
   logic [SAMPLE_W-1:0]      base_ff;
   logic signed [READ_W-1:0] low_point_ff, high_point_ff;
   logic signed [SUM_W-1:0]  run_sum_ff;
   logic [AVG_SHIFT-1:0]     run_cnt_ff;
   logic [KIND_W-1:0]        run_kind_ff;

   // Item working registers.
   logic [KIND_W-1:0]        kind_ff;
   logic signed [READ_W-1:0] reading_ff, reading_in;
   logic signed [DIFF_W-1:0] diff_ff, den_ff;
   logic signed [NUM_W-1:0]  num_ff, num_in;
   logic [PCT_W-1:0]         pct_ff;
   logic                     done_ff, ok_ff;

   // Output register.
   logic                     rsp_valid_ff;
   logic signed [READ_W-1:0] rsp_reading_ff;
   logic [PCT_W-1:0]         rsp_percent_ff;
   logic                     rsp_done_ff, rsp_ok_ff;

   // Calibration run arithmetic.
   logic                     fresh, last;
   logic signed [SUM_W-1:0]  sum_base, sum_new;
   logic [AVG_SHIFT-1:0]     cnt_base;
   logic signed [READ_W-1:0] point;
   logic                     cal_ok;

   // Divider interface.
   div_req_type              div_req;
   div_rsp_type              div_rsp;
   logic [PCT_W-1:0]         pct_clamped;

   // Inverted reading of the incoming sample.
   assign reading_in = READ_W'({1'b0, base_ff}) - READ_W'({1'b0, req_sample});

   assign is_cal = (kind_ff == KIND_LOW_CAL) || (kind_ff == KIND_HIGH_CAL);

   // Zero percentage without division: equal points, zero numerator or opposite signs.
   assign trivial_zero = (den_ff == '0) || (num_ff == '0) ||
                         (num_ff[NUM_W-1] != den_ff[DIFF_W-1]);

   // Scaled numerator; product is kept modulo its width.
   assign num_in = NUM_W'(diff_ff) * NUM_W'(PCT_MAX);

   // Calibration run: restart on a change of kind, finish on the last sample.
   always_comb begin
      fresh    = run_kind_ff != kind_ff;
      sum_base = fresh ? '0 : run_sum_ff;
      cnt_base = fresh ? '0 : run_cnt_ff;
      sum_new  = sum_base + SUM_W'(reading_ff);
      last     = cnt_base == AVG_SHIFT'(RUN_LEN - 1);
      point    = READ_W'(sum_new >>> AVG_SHIFT);
      if (kind_ff == KIND_LOW_CAL) begin
         cal_ok = point < high_point_ff;
      end else begin
         cal_ok = low_point_ff < point;
      end
   end

   // Divider operands are the magnitudes of numerator and denominator.
   always_comb begin
      div_req.start    = do_sign && !trivial_zero;
      div_req.dividend = num_ff[NUM_W-1] ? DIVIDEND_W'(-num_ff) : DIVIDEND_W'(num_ff);
      div_req.divisor  = den_ff[DIFF_W-1] ? DIVISOR_W'(-den_ff) : DIVISOR_W'(den_ff);
   end

   lscs_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Clamp the quotient to the top of the scale.
   assign pct_clamped = (div_rsp.quotient > DIVIDEND_W'(PCT_MAX)) ?
                        PCT_W'(PCT_MAX) : PCT_W'(div_rsp.quotient);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_PREP;
         end
         ST_PREP: begin
            state_in = is_cal ? ST_DONE : ST_MUL;
         end
         ST_MUL: begin
            state_in = ST_SIGN;
         end
         ST_SIGN: begin
            state_in = trivial_zero ? ST_DONE : ST_DIV;
         end
         ST_DIV: begin
            if (div_rsp.done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall  = 1'b1;
      load_item  = 1'b0;
      do_prep    = 1'b0;
      do_mul     = 1'b0;
      do_sign    = 1'b0;
      div_finish = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            load_item = req_valid;
         end
         ST_PREP: begin
            do_prep = 1'b1;
         end
         ST_MUL: begin
            do_mul = 1'b1;
         end
         ST_SIGN: begin
            do_sign = 1'b1;
         end
         ST_DIV: begin
            div_finish = div_rsp.done;
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Control state: sequencer, configuration, calibration run, output valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         base_ff       <= SAMPLE_W'(BASE_RESET);
         low_point_ff  <= READ_W'(LOW_RESET);
         high_point_ff <= READ_W'(HIGH_RESET);
         run_sum_ff    <= '0;
         run_cnt_ff    <= '0;
         run_kind_ff   <= KIND_NONE;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         // Register writes; a default write also loads its working point.
         if (csr_write) begin
            case (csr_index)
               CSR_BASE_VALUE:   base_ff       <= csr_data[SAMPLE_W-1:0];
               CSR_LOW_DEFAULT:  low_point_ff  <= csr_data;
               CSR_HIGH_DEFAULT: high_point_ff <= csr_data;
               default: begin
               end
            endcase
         end
         // One calibration sample.
         if (do_prep && is_cal) begin
            if (last) begin
               if (kind_ff == KIND_LOW_CAL) begin
                  low_point_ff <= point;
               end else begin
                  high_point_ff <= point;
               end
               run_sum_ff  <= '0;
               run_cnt_ff  <= '0;
               run_kind_ff <= KIND_NONE;
            end else begin
               run_sum_ff  <= sum_new;
               run_cnt_ff  <= cnt_base + 1'b1;
               run_kind_ff <= kind_ff;
            end
         end
         // Output register holds a result until its transfer.
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Item datapath registers.
   always_ff @(posedge clock) begin
      if (load_item) begin
         kind_ff    <= req_kind;
         reading_ff <= reading_in;
      end
      if (do_prep) begin
         diff_ff <= DIFF_W'(reading_ff) - DIFF_W'(low_point_ff);
         den_ff  <= DIFF_W'(high_point_ff) - DIFF_W'(low_point_ff);
         pct_ff  <= '0;
         done_ff <= is_cal && last;
         ok_ff   <= is_cal && last && cal_ok;
      end
      if (do_mul) begin
         num_ff <= num_in;
      end
      if (div_finish) begin
         pct_ff <= pct_clamped;
      end
      if (rsp_load) begin
         rsp_reading_ff <= reading_ff;
         rsp_percent_ff <= pct_ff;
         rsp_done_ff    <= done_ff;
         rsp_ok_ff      <= ok_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_reading    = rsp_reading_ff;
   assign rsp_percent    = rsp_percent_ff;
   assign rsp_calib_done = rsp_done_ff;
   assign rsp_calib_ok   = rsp_ok_ff;

endmodule

// ----- rtl/lscs_div.sv -----
// Restoring serial divider, one quotient bit per clock cycle.
module lscs_div
   import lscs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;
   logic [REM_W-1:0]      rem_shift;
   logic [REM_W-1:0]      trial;
   logic                  fits;

   // One trial subtraction of the shifted remainder.
   always_comb begin
      rem_shift = {rem_ff[REM_W-2:0], quo_ff[DIVIDEND_W-1]};
      trial     = rem_shift - {1'b0, dsr_ff};
      fits      = rem_shift >= {1'b0, dsr_ff};
   end

   // Next values: load on start, then, while busy, shift one quotient bit in each cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(DIVIDEND_W - 1);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], fits};
         rem_in = fits ? trial : rem_shift;
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dsr_ff  <= dsr_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

// ----- dv/tb_light_sample_calibrate_scale_unit.sv -----
// Self-checking testbench of the light sample calibrate and scale unit.
module tb_light_sample_calibrate_scale_unit
   import lscs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Kind and register codes outside the package's list.
   localparam logic [KIND_W-1:0]    KIND_SPARE = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE  = 2'd3;

   localparam int RANDOM_ITEMS = 750;
   localparam int PHASE_ITEMS  = 75;
   localparam int IDLE_MARGIN  = 4;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 600000;

   // One expected result transfer.
   typedef struct packed {
      logic [READ_W-1:0] reading;
      logic [PCT_W-1:0]  percent;
      logic              calib_done;
      logic              calib_ok;
   } light_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [KIND_W-1:0]     req_kind = KIND_MEASURE;
   logic [SAMPLE_W-1:0]   req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic signed [READ_W-1:0] rsp_reading;
   logic [PCT_W-1:0]      rsp_percent;
   logic                  rsp_calib_done;
   logic                  rsp_calib_ok;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = CSR_BASE_VALUE;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Predictor copy of the registers and the calibration state.
   logic [SAMPLE_W-1:0]      base_val = SAMPLE_W'(BASE_RESET);
   logic signed [READ_W-1:0] low_pt   = READ_W'(LOW_RESET);
   logic signed [READ_W-1:0] high_pt  = READ_W'(HIGH_RESET);
   int                       run_sum  = 0;
   int                       run_cnt  = 0;
   logic [KIND_W-1:0]        run_kind = KIND_NONE;

   light_result_type pending_results[$];
   int errors      = 0;
   int items_sent  = 0;
   int writes_done = 0;
   int runs_seen   = 0;
   int burst_left  = 0;
   int cycle_count = 0;
   int stall_mode  = 0;
   int mode_cycles = 0;

   light_sample_calibrate_scale_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_kind       (req_kind),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_reading    (rsp_reading),
      .rsp_percent    (rsp_percent),
      .rsp_calib_done (rsp_calib_done),
      .rsp_calib_ok   (rsp_calib_ok),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
         $display("tb_light_sample_calibrate_scale_unit NOT OK");
         $finish;
      end
   end

   // Receiver stall pattern: long stretches of no stall, light stall or heavy stall.
   always @(posedge clock) begin
      if (mode_cycles == 0) begin
         stall_mode  = $urandom_range(0, 2);
         mode_cycles = $urandom_range(20, 200);
      end
      mode_cycles--;
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 99) < 35);
         default: rsp_stall <= ($urandom_range(0, 99) < 85);
      endcase
   end

   // Computes the result of one item and advances the calibration state.
   function automatic light_result_type calibrate_and_scale(input logic [KIND_W-1:0] kind,
                                                            input logic [SAMPLE_W-1:0] raw);
      light_result_type res;
      int reading;
      int lo;
      int hi;
      int den;
      int q;
      int point;
      reading = int'(base_val) - int'(raw);
      res = '0;
      if (kind == KIND_LOW_CAL || kind == KIND_HIGH_CAL) begin
         // A different calibration kind throws the partial run away.
         if (run_kind != kind) begin
            run_kind = kind;
            run_sum  = 0;
            run_cnt  = 0;
         end
         run_sum += reading;
         run_cnt++;
         if (run_cnt >= RUN_LEN) begin
            point = run_sum >>> AVG_SHIFT;
            if (kind == KIND_LOW_CAL) begin
               low_pt = point[READ_W-1:0];
            end else begin
               high_pt = point[READ_W-1:0];
            end
            lo = int'(low_pt);
            hi = int'(high_pt);
            res.calib_done = 1'b1;
            res.calib_ok   = (lo < hi);
            run_kind = KIND_NONE;
            run_sum  = 0;
            run_cnt  = 0;
         end
      end else begin
         // Measure, and the spare kind as a measure: linear map with clamp.
         lo  = int'(low_pt);
         hi  = int'(high_pt);
         den = hi - lo;
         if (den == 0) begin
            q = 0;
         end else begin
            q = ((reading - lo) * PCT_MAX) / den;
         end
         if (q < 0) q = 0;
         if (q > PCT_MAX) q = PCT_MAX;
         res.percent = q[PCT_W-1:0];
      end
      res.reading = reading[READ_W-1:0];
      return res;
   endfunction

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   // Result checker: every result transfer is matched against the oldest expectation.
   always @(posedge clock) begin
      light_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual reading %0d percent %0d",
                     $time, rsp_reading, rsp_percent);
            errors++;
         end else begin
            want = pending_results.pop_front();
            check_field("reading", int'($signed(want.reading)), int'(rsp_reading));
            check_field("percent", int'(want.percent), int'(rsp_percent));
            check_field("calib_done", int'(want.calib_done), int'(rsp_calib_done));
            check_field("calib_ok", int'(want.calib_ok), int'(rsp_calib_ok));
            if (want.calib_done) runs_seen++;
         end
      end
   end

   // Sends one item in bursts of random length with random gaps in between.
   task automatic send_item(input logic [KIND_W-1:0] kind, input logic [SAMPLE_W-1:0] raw);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid  <= 1'b1;
      req_kind   <= kind;
      req_sample <= raw;
      do @(posedge clock); while (req_stall);
      pending_results.push_back(calibrate_and_scale(kind, raw));
      burst_left--;
      items_sent++;
   endtask

   // Stops sending and waits until every expected result has been transferred.
   task automatic wait_until_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (IDLE_MARGIN) @(posedge clock);
      burst_left = 0;
   endtask

   // Writes one register; the block must be idle.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      csr_write <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_BASE_VALUE:   base_val = data[SAMPLE_W-1:0];
         CSR_LOW_DEFAULT:  low_pt   = data;
         CSR_HIGH_DEFAULT: high_pt  = data;
         default: ;
      endcase
      writes_done++;
   endtask

   function automatic logic [SAMPLE_W-1:0] raw_near(input int center, input int spread);
      int v;
      v = center + $urandom_range(0, 2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > BASE_RESET) v = BASE_RESET;
      return v[SAMPLE_W-1:0];
   endfunction

   // Measures with the reset settings, including the spare kind.
   task automatic test_reset_points();
      send_item(KIND_MEASURE, '0);
      send_item(KIND_MEASURE, '1);
      send_item(KIND_MEASURE, 10'd512);
      send_item(KIND_SPARE, 10'd700);
   endtask

   // Negative readings, the widest span, equal points and reversed points.
   task automatic test_mapped_extremes();
      wait_until_drained();
      write_register(CSR_BASE_VALUE, '0);
      write_register(CSR_LOW_DEFAULT, CSR_DATA_W'(-1024));
      write_register(CSR_HIGH_DEFAULT, CSR_DATA_W'(1023));
      send_item(KIND_MEASURE, '1);
      send_item(KIND_MEASURE, '0);
      // Equal points give zero.
      wait_until_drained();
      write_register(CSR_LOW_DEFAULT, CSR_DATA_W'(100));
      write_register(CSR_HIGH_DEFAULT, CSR_DATA_W'(100));
      send_item(KIND_MEASURE, 10'd300);
      // Reversed points: negative divisor, clamped both ways.
      wait_until_drained();
      write_register(CSR_BASE_VALUE, CSR_DATA_W'(1023));
      write_register(CSR_LOW_DEFAULT, CSR_DATA_W'(800));
      write_register(CSR_HIGH_DEFAULT, CSR_DATA_W'(200));
      send_item(KIND_MEASURE, 10'd123);
      send_item(KIND_MEASURE, 10'd923);
   endtask

   // Kind change, a measure inside a run, and a register write inside a run.
   task automatic test_calibration_runs();
      int i;
      send_item(KIND_HIGH_CAL, 10'd100);
      send_item(KIND_HIGH_CAL, 10'd110);
      send_item(KIND_MEASURE, 10'd400);
      for (i = 0; i < RUN_LEN; i++) begin
         if (i == RUN_LEN / 2) begin
            wait_until_drained();
            write_register(CSR_BASE_VALUE, CSR_DATA_W'(1000));
         end
         send_item(KIND_LOW_CAL, raw_near(900, 40));
      end
   endtask

   // Picks a new group of settings, extremes included.
   task automatic pick_settings(input bit all);
      logic [CSR_DATA_W-1:0] v;
      logic [CSR_DATA_W-1:0] lo_v;
      if (all || $urandom_range(0, 1)) begin
         case ($urandom_range(0, 3))
            0: v = '0;
            1: begin v = CSR_DATA_W'($urandom); v[SAMPLE_W-1:0] = '1; end
            default: v = CSR_DATA_W'($urandom);
         endcase
         write_register(CSR_BASE_VALUE, v);
      end
      case ($urandom_range(0, 4))
         0: lo_v = CSR_DATA_W'(-1024);
         1: lo_v = CSR_DATA_W'(-1023);
         2: lo_v = CSR_DATA_W'(1023);
         default: lo_v = CSR_DATA_W'($urandom);
      endcase
      if (all || $urandom_range(0, 1)) write_register(CSR_LOW_DEFAULT, lo_v);
      if (all || $urandom_range(0, 1)) begin
         case ($urandom_range(0, 5))
            0: v = CSR_DATA_W'(-1023);
            1: v = CSR_DATA_W'(1023);
            2: v = low_pt;
            default: v = CSR_DATA_W'($urandom);
         endcase
         write_register(CSR_HIGH_DEFAULT, v);
      end
      if ($urandom_range(0, 4) == 0) write_register(CSR_SPARE, CSR_DATA_W'($urandom));
   endtask

   // Mostly complete calibration runs and measures, with broken runs mixed in.
   task automatic run_random_phase(input int count);
      int done;
      int n;
      int i;
      int center;
      int spread;
      int cut;
      logic [KIND_W-1:0] kind;
      done = 0;
      while (done < count) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               kind   = $urandom_range(0, 1) ? KIND_LOW_CAL : KIND_HIGH_CAL;
               center = $urandom_range(0, 1023);
               spread = $urandom_range(0, 1) ? $urandom_range(0, 30) : 600;
               // Some runs are broken off early by whatever follows.
               n      = ($urandom_range(0, 4) == 0) ? $urandom_range(1, RUN_LEN - 1) : RUN_LEN;
               cut    = ($urandom_range(0, 4) == 0) ? $urandom_range(1, n) : -1;
               for (i = 0; i < n; i++) begin
                  if (i == cut) send_item(KIND_MEASURE, SAMPLE_W'($urandom));
                  send_item(kind, raw_near(center, spread));
               end
               done += n;
            end
            default: begin
               n = $urandom_range(1, 6);
               for (i = 0; i < n; i++) begin
                  kind = ($urandom_range(0, 7) == 0) ? KIND_SPARE : KIND_MEASURE;
                  case ($urandom_range(0, 7))
                     0: send_item(kind, '0);
                     1: send_item(kind, '1);
                     default: send_item(kind, SAMPLE_W'($urandom));
                  endcase
               end
               done += n;
            end
         endcase
      end
   endtask

   task automatic test_random_traffic();
      int phase;
      for (phase = 0; phase < RANDOM_ITEMS / PHASE_ITEMS; phase++) begin
         wait_until_drained();
         // The first phase goes back to a typical setting with every register written.
         if (phase == 0) begin
            write_register(CSR_BASE_VALUE, CSR_DATA_W'(BASE_RESET));
            write_register(CSR_LOW_DEFAULT, CSR_DATA_W'(LOW_RESET));
            write_register(CSR_HIGH_DEFAULT, CSR_DATA_W'(HIGH_RESET));
         end else begin
            pick_settings(phase == 1);
         end
         run_random_phase(PHASE_ITEMS);
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_points();
      test_mapped_extremes();
      test_calibration_runs();
      test_random_traffic();
      // Drain everything and watch for stray results.
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d items over %0d register writes; %0d calibration runs completed.",
               items_sent, writes_done, runs_seen);
      if (errors == 0) begin
         $display("tb_light_sample_calibrate_scale_unit OK");
      end else begin
         $display("%0d mismatches found.", errors);
         $display("tb_light_sample_calibrate_scale_unit NOT OK");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/lscs_pkg.sv
rtl/lscs_div.sv
rtl/light_sample_calibrate_scale_unit.sv
dv/tb_light_sample_calibrate_scale_unit.sv
